>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the pedestal correction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/apc_pkg.sv
// Package with widths, codes and state types of the pedestal correction block.
package apc_pkg;

  localparam int CHANNELS_DEF = 12;
  localparam int ADC_BITS_DEF = 12;

  localparam int CH_W       = 4;
  localparam int COEF_W     = 16;
  localparam int SCALE_FRAC = 12;
  localparam int FRAC_W     = 4;
  localparam int COR_W      = 24;
  localparam int SUM_W      = 32;
  localparam int HIT_W      = 4;
  localparam int ZC_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [ZC_W-1:0] ZERO_CUT_RST = 8'd5;

  typedef enum logic {
    ITEM_SAMPLE = 1'b0,
    ITEM_LOAD   = 1'b1
  } item_mode_t;

  typedef enum logic [1:0] {
    TBL_SCALE     = 2'd0,
    TBL_OFFSET    = 2'd1,
    TBL_THRESHOLD = 2'd2,
    TBL_PEDESTAL  = 2'd3
  } table_sel_t;

  typedef enum logic [1:0] {
    CM_OFFSET_GAIN    = 2'd0,
    CM_GAIN_MINUS_PED = 2'd1,
    CM_GAIN_OVER_PED  = 2'd2,
    CM_SHIFT_CUT      = 2'd3
  } corr_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORRECTION_MODE = 2'd0,
    REG_ZERO_CUT        = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_ROUND,
    ST_FIN,
    ST_ACC
  } st_t;

endpackage

>>> src/apc_in_if.sv
// Input request channel: samples and coefficient loads.
interface apc_in_if import apc_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [CH_W-1:0]          channel;
  logic [1:0]               table_select;
  logic signed [COEF_W-1:0] load_value;
  logic [ADC_BITS-1:0]      energy;
  logic                     sample_valid;
  logic                     last_in_event;

  modport source (
    output valid, mode, channel, table_select, load_value, energy, sample_valid,
           last_in_event,
    input  ready
  );

  modport sink (
    input  valid, mode, channel, table_select, load_value, energy, sample_valid,
           last_in_event,
    output ready
  );
endinterface

>>> src/apc_out_if.sv
// Result channel: corrected sample with event sum and hit count.
interface apc_out_if import apc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         out_channel;
  logic signed [COR_W-1:0] corrected;
  logic signed [SUM_W-1:0] event_sum;
  logic [HIT_W-1:0]        hit_count;
  logic                    event_done;
  logic                    divide_fault;

  modport source (
    output valid, out_channel, corrected, event_sum, hit_count, event_done, divide_fault,
    input  ready
  );

  modport sink (
    input  valid, out_channel, corrected, event_sum, hit_count, event_done, divide_fault,
    output ready
  );
endinterface

>>> src/apc_cfg_if.sv
// Configuration write channel: register index and write data.
interface apc_cfg_if import apc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

>>> src/apc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module apc_ram import apc_pkg::*; #(
  parameter int WIDTH = COEF_W,
  parameter int DEPTH = CHANNELS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/adc_pedestal_correct_sum_hits.sv
// Top level of the pedestal and gain correction block with event sum and hit count.
//
// Each sample request is corrected with the per-channel scale, offset, threshold and
// pedestal held in four small RAMs, and gives one result with the running event sum and
// hit count; a coefficient load request writes one table entry and gives no result. A
// sample runs through a bit-serial shift-add multiplier of MB = max(ADC_BITS+4, 16)+1
// steps, so offset, pedestal and threshold modes pass the read, multiply, round, final
// and accumulate states. The ratio mode adds a restoring divider that yields one
// quotient bit per cycle over 16+ADC_BITS bits after the multiply and skips rounding.
// Invalid samples, out-of-range channels, zero pedestals in ratio mode and values
// removed by the zero cut go from the read state straight to the accumulate state. The
// next request is taken while a finished result still waits in the output register.
// Tables are not cleared at reset and must be loaded before use.
`include "assert_macros.svh"

module adc_pedestal_correct_sum_hits import apc_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  apc_in_if.sink     in_bus,
  apc_out_if.source  out_bus,
  apc_cfg_if.sink    cfg_bus
);

  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int E16_W  = ADC_BITS + FRAC_W;
  localparam int SH_W   = ((E16_W > COEF_W) ? E16_W : COEF_W) + 2;
  localparam int MB_W   = SH_W - 1;
  localparam int P_W    = COEF_W + MB_W;
  localparam int DV_W   = COEF_W + ADC_BITS;
  localparam int DS_W   = COEF_W + FRAC_W;
  localparam int RS_LO  = SCALE_FRAC - FRAC_W;
  localparam int RS_HI  = SCALE_FRAC;
  localparam int R_W    = P_W + 1 - RS_LO;
  localparam int CNT_W  = $clog2(((MB_W > DV_W) ? MB_W : DV_W) + 1);
  localparam int SATIN_W = 48;

  localparam logic [P_W:0] HALF_LO = (P_W + 1)'(1) << (RS_LO - 1);
  localparam logic [P_W:0] HALF_HI = (P_W + 1)'(1) << (RS_HI - 1);

  localparam logic signed [COR_W-1:0] COR_MAX = {1'b0, {(COR_W - 1){1'b1}}};
  localparam logic signed [COR_W-1:0] COR_MIN = {1'b1, {(COR_W - 1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

  function automatic logic signed [COR_W-1:0] sat_cor(input logic signed [SATIN_W-1:0] v);
    logic [SATIN_W-COR_W:0] hi;
    hi = v[SATIN_W-1:COR_W-1];
    if ((&hi) || !(|hi)) begin
      return v[COR_W-1:0];
    end else if (v[SATIN_W-1]) begin
      return COR_MIN;
    end else begin
      return COR_MAX;
    end
  endfunction

  st_t state_r, state_nxt;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CH_W-1:0]         ch_r, ch_nxt;
  logic [AW-1:0]           ch_addr_r, ch_addr_nxt;
  logic [ADC_BITS-1:0]     e_r, e_nxt;
  logic                    ok_r, ok_nxt;
  logic                    last_r, last_nxt;
  logic                    fault_r, fault_nxt;
  logic                    neg_r, neg_nxt;
  logic [COEF_W-1:0]       mag_r, mag_nxt;
  logic [P_W-1:0]          prod_r, prod_nxt;
  logic [DS_W-1:0]         rem_r, rem_nxt;
  logic [R_W-1:0]          r_r, r_nxt;
  logic signed [COR_W-1:0] cor_r, cor_nxt;

  logic signed [SUM_W-1:0] running_sum_r, running_sum_nxt;
  logic [HIT_W-1:0]        running_hits_r, running_hits_nxt;
  corr_mode_t              corr_mode_r, corr_mode_nxt;
  logic [ZC_W-1:0]         zero_cut_r, zero_cut_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]         och_r, och_nxt;
  logic signed [COR_W-1:0] ocor_r, ocor_nxt;
  logic signed [SUM_W-1:0] osum_r, osum_nxt;
  logic [HIT_W-1:0]        ohits_r, ohits_nxt;
  logic                    odone_r, odone_nxt;
  logic                    ofault_r, ofault_nxt;

  logic                    in_acc;
  logic [AW+CH_W-1:0]      ch_ext;
  logic [AW-1:0]           in_addr;
  logic                    in_range;
  logic [AW-1:0]           raddr;
  logic                    load_ok;
  logic [COEF_W-1:0]       scale_q, offset_q, thr_q, ped_q;

  logic signed [SH_W-1:0]  sh;
  logic                    cut;
  logic [COEF_W:0]         mul_add;
  logic [DS_W:0]           trial;
  logic [DS_W:0]           dvs;
  logic [DS_W:0]           div_diff;
  logic                    div_ge;
  logic [P_W:0]            rnd;
  logic signed [SATIN_W-1:0] fin_val;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] sum_sat;
  logic signed [COR_W-1:0] thr_cor;
  logic                    hit;
  logic [HIT_W-1:0]        hits_after;
  logic signed [SUM_W-1:0] sum_after;
  logic                    slot_free;

  assign in_bus.ready  = (state_r == ST_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign in_acc        = in_bus.valid && in_bus.ready;

  assign ch_ext   = {{AW{1'b0}}, in_bus.channel};
  assign in_addr  = ch_ext[AW-1:0];
  assign in_range = ch_ext < (AW + CH_W)'(CHANNELS);
  assign raddr    = (state_r == ST_IDLE) ? in_addr : ch_addr_r;
  assign load_ok  = in_acc && (item_mode_t'(in_bus.mode) == ITEM_LOAD) && in_range;

  apc_ram #(.WIDTH(COEF_W), .DEPTH(CHANNELS)) u_scale_ram (
    .clk   (clk),
    .we    (load_ok && (table_sel_t'(in_bus.table_select) == TBL_SCALE)),
    .waddr (in_addr),
    .wdata (in_bus.load_value),
    .raddr (raddr),
    .rdata (scale_q)
  );

  apc_ram #(.WIDTH(COEF_W), .DEPTH(CHANNELS)) u_offset_ram (
    .clk   (clk),
    .we    (load_ok && (table_sel_t'(in_bus.table_select) == TBL_OFFSET)),
    .waddr (in_addr),
    .wdata (in_bus.load_value),
    .raddr (raddr),
    .rdata (offset_q)
  );

  apc_ram #(.WIDTH(COEF_W), .DEPTH(CHANNELS)) u_thr_ram (
    .clk   (clk),
    .we    (load_ok && (table_sel_t'(in_bus.table_select) == TBL_THRESHOLD)),
    .waddr (in_addr),
    .wdata (in_bus.load_value),
    .raddr (raddr),
    .rdata (thr_q)
  );

  apc_ram #(.WIDTH(COEF_W), .DEPTH(CHANNELS)) u_ped_ram (
    .clk   (clk),
    .we    (load_ok && (table_sel_t'(in_bus.table_select) == TBL_PEDESTAL)),
    .waddr (in_addr),
    .wdata (in_bus.load_value),
    .raddr (raddr),
    .rdata (ped_q)
  );

  assign sh  = $signed({{(SH_W - E16_W){1'b0}}, e_r, {FRAC_W{1'b0}}})
             - $signed({{(SH_W - COEF_W){thr_q[COEF_W-1]}}, thr_q});
  assign cut = sh <= $signed({{(SH_W - ZC_W - FRAC_W){1'b0}}, zero_cut_r, {FRAC_W{1'b0}}});

  assign mul_add = {1'b0, prod_r[P_W-1:MB_W]} + (prod_r[0] ? {1'b0, scale_q} : '0);

  assign trial    = {rem_r, prod_r[DV_W-1]};
  assign dvs      = {1'b0, mag_r, {FRAC_W{1'b0}}};
  assign div_diff = trial - dvs;
  assign div_ge   = trial >= dvs;

  assign rnd = {1'b0, prod_r} + ((corr_mode_r == CM_SHIFT_CUT) ? HALF_HI : HALF_LO);

  always_comb begin
    case (corr_mode_r)
      CM_OFFSET_GAIN: begin
        fin_val = $signed({{(SATIN_W - COEF_W){offset_q[COEF_W-1]}}, offset_q})
                + $signed({{(SATIN_W - R_W){1'b0}}, r_r});
      end
      CM_GAIN_MINUS_PED: begin
        fin_val = $signed({{(SATIN_W - R_W){1'b0}}, r_r})
                - $signed({{(SATIN_W - COEF_W){ped_q[COEF_W-1]}}, ped_q});
      end
      CM_GAIN_OVER_PED: begin
        if (neg_r) begin
          fin_val = -$signed({{(SATIN_W - DV_W){1'b0}}, prod_r[DV_W-1:0]});
        end else begin
          fin_val = $signed({{(SATIN_W - DV_W){1'b0}}, prod_r[DV_W-1:0]});
        end
      end
      default: begin
        fin_val = $signed({{(SATIN_W - R_W){1'b0}}, r_r});
      end
    endcase
  end

  assign sum_ext = $signed({running_sum_r[SUM_W-1], running_sum_r})
                 + $signed({{(SUM_W + 1 - COR_W){cor_r[COR_W-1]}}, cor_r});
  assign sum_sat = (sum_ext[SUM_W] != sum_ext[SUM_W-1])
                 ? (sum_ext[SUM_W] ? SUM_MIN : SUM_MAX) : sum_ext[SUM_W-1:0];
  assign thr_cor = $signed({{(COR_W - COEF_W){thr_q[COEF_W-1]}}, thr_q});
  assign hit     = ok_r && !fault_r
                 && ((corr_mode_r == CM_SHIFT_CUT) ? (!cor_r[COR_W-1] && (cor_r != '0))
                                                    : (cor_r >= thr_cor));
  assign hits_after = (hit && (running_hits_r != '1)) ? running_hits_r + 1'b1
                                                      : running_hits_r;
  assign sum_after  = ok_r ? sum_sat : running_sum_r;
  assign slot_free  = !out_valid_r || out_bus.ready;

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    ch_nxt           = ch_r;
    ch_addr_nxt      = ch_addr_r;
    e_nxt            = e_r;
    ok_nxt           = ok_r;
    last_nxt         = last_r;
    fault_nxt        = fault_r;
    neg_nxt          = neg_r;
    mag_nxt          = mag_r;
    prod_nxt         = prod_r;
    rem_nxt          = rem_r;
    r_nxt            = r_r;
    cor_nxt          = cor_r;
    running_sum_nxt  = running_sum_r;
    running_hits_nxt = running_hits_r;
    corr_mode_nxt    = corr_mode_r;
    zero_cut_nxt     = zero_cut_r;
    out_valid_nxt    = out_valid_r && !out_bus.ready;
    och_nxt          = och_r;
    ocor_nxt         = ocor_r;
    osum_nxt         = osum_r;
    ohits_nxt        = ohits_r;
    odone_nxt        = odone_r;
    ofault_nxt       = ofault_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (item_mode_t'(in_bus.mode) == ITEM_SAMPLE)) begin
          ch_nxt      = in_bus.channel;
          ch_addr_nxt = in_addr;
          e_nxt       = in_bus.energy;
          ok_nxt      = in_bus.sample_valid && in_range;
          last_nxt    = in_bus.last_in_event;
          fault_nxt   = 1'b0;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cnt_nxt  = CNT_W'(MB_W);
        neg_nxt  = ped_q[COEF_W-1];
        mag_nxt  = ped_q[COEF_W-1] ? (~ped_q + 1'b1) : ped_q;
        cor_nxt  = '0;
        prod_nxt = {{(P_W - ADC_BITS){1'b0}}, e_r};
        if (!ok_r) begin
          state_nxt = ST_ACC;
        end else begin
          case (corr_mode_r)
            CM_SHIFT_CUT: begin
              if (cut) begin
                state_nxt = ST_ACC;
              end else begin
                prod_nxt  = {{COEF_W{1'b0}}, sh[MB_W-1:0]};
                state_nxt = ST_MUL;
              end
            end
            CM_GAIN_OVER_PED: begin
              if (ped_q == '0) begin
                fault_nxt = 1'b1;
                state_nxt = ST_ACC;
              end else begin
                state_nxt = ST_MUL;
              end
            end
            default: begin
              state_nxt = ST_MUL;
            end
          endcase
        end
      end
      ST_MUL: begin
        prod_nxt = {mul_add, prod_r[MB_W-1:1]};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          if (corr_mode_r == CM_GAIN_OVER_PED) begin
            cnt_nxt   = CNT_W'(DV_W);
            rem_nxt   = '0;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? div_diff[DS_W-1:0] : trial[DS_W-1:0];
        prod_nxt = {prod_r[P_W-2:0], div_ge};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_ROUND: begin
        if (corr_mode_r == CM_SHIFT_CUT) begin
          r_nxt = R_W'(rnd[P_W:RS_HI]);
        end else begin
          r_nxt = rnd[P_W:RS_LO];
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cor_nxt   = sat_cor(fin_val);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          och_nxt          = ch_r;
          ocor_nxt         = cor_r;
          osum_nxt         = sum_after;
          ohits_nxt        = hits_after;
          odone_nxt        = last_r;
          ofault_nxt       = fault_r;
          running_sum_nxt  = last_r ? '0 : sum_after;
          running_hits_nxt = last_r ? '0 : hits_after;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_reg_t'(cfg_bus.index))
        REG_CORRECTION_MODE: corr_mode_nxt = corr_mode_t'(cfg_bus.data[1:0]);
        REG_ZERO_CUT:        zero_cut_nxt  = cfg_bus.data[ZC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      running_sum_r  <= '0;
      running_hits_r <= '0;
      corr_mode_r    <= CM_OFFSET_GAIN;
      zero_cut_r     <= ZERO_CUT_RST;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      running_sum_r  <= running_sum_nxt;
      running_hits_r <= running_hits_nxt;
      corr_mode_r    <= corr_mode_nxt;
      zero_cut_r     <= zero_cut_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    ch_r      <= ch_nxt;
    ch_addr_r <= ch_addr_nxt;
    e_r       <= e_nxt;
    ok_r      <= ok_nxt;
    last_r    <= last_nxt;
    fault_r   <= fault_nxt;
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    r_r       <= r_nxt;
    cor_r     <= cor_nxt;
    och_r     <= och_nxt;
    ocor_r    <= ocor_nxt;
    osum_r    <= osum_nxt;
    ohits_r   <= ohits_nxt;
    odone_r   <= odone_nxt;
    ofault_r  <= ofault_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.out_channel  = och_r;
  assign out_bus.corrected    = ocor_r;
  assign out_bus.event_sum    = osum_r;
  assign out_bus.hit_count    = ohits_r;
  assign out_bus.event_done   = odone_r;
  assign out_bus.divide_fault = ofault_r;

  // A zero pedestal in ratio mode must give a zero value, and only ratio mode may flag it.
  `ASSERT_IMPL(a_fault_zero, clk, rst_n, out_bus.valid && out_bus.divide_fault, out_bus.corrected == '0, "divide fault with nonzero value")
  `ASSERT_IMPL(a_fault_mode, clk, rst_n, out_bus.valid && out_bus.divide_fault, corr_mode_r == CM_GAIN_OVER_PED, "divide fault outside ratio mode")
  `ASSERT_CLK(a_hits_step, clk, rst_n, running_hits_r != $past(running_hits_r) |-> running_hits_r == $past(running_hits_r) + 4'd1 || running_hits_r == '0, "hit count jumped")
  `ASSERT_CLK(a_busy_after_sample, clk, rst_n, in_bus.valid && in_bus.ready && in_bus.mode == ITEM_SAMPLE |=> !in_bus.ready, "sample request did not block input")

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench of the pedestal and gain correction block with event sum and hit count.
module tb_top;
  import apc_pkg::*;

  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     DRAIN_CYCLES   = 64;
  localparam int     MAX_REPORTS    = 10;
  localparam int     HIT_MAX        = 2**HIT_W - 1;
  localparam longint COR_MAX        = (longint'(1) <<< (COR_W - 1)) - 1;
  localparam longint COR_MIN        = -(longint'(1) <<< (COR_W - 1));
  localparam longint SUM_MAX        = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_MIN        = -(longint'(1) <<< (SUM_W - 1));
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    item_mode_t               mode;
    logic [CH_W-1:0]          channel;
    table_sel_t               tsel;
    logic signed [COEF_W-1:0] load_value;
    logic [ADC_BITS_DEF-1:0]  energy;
    logic                     sample_valid;
    logic                     last_in_event;
    int                       lead_gap;
  } apc_req_t;

  typedef struct {
    logic [CH_W-1:0]         out_channel;
    logic signed [COR_W-1:0] corrected;
    logic signed [SUM_W-1:0] event_sum;
    logic [HIT_W-1:0]        hit_count;
    logic                    event_done;
    logic                    divide_fault;
  } corr_result_t;

  logic clk = 1'b0;
  logic rst_n;

  apc_in_if  in_bus ();
  apc_out_if out_bus ();
  apc_cfg_if cfg_bus ();

  adc_pedestal_correct_sum_hits u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  logic [COEF_W-1:0]        scale_tbl  [CHANNELS_DEF];
  logic signed [COEF_W-1:0] offset_tbl [CHANNELS_DEF];
  logic signed [COEF_W-1:0] thresh_tbl [CHANNELS_DEF];
  logic signed [COEF_W-1:0] ped_tbl    [CHANNELS_DEF];
  longint                   pred_sum;
  logic [HIT_W-1:0]         pred_hits;
  corr_mode_t               pred_mode;
  logic [ZC_W-1:0]          pred_cut;

  apc_req_t     pending_reqs[$];
  corr_result_t expected_results[$];

  bit in_taken    = 1'b0;
  bit out_taken   = 1'b0;
  bit quiet_phase = 1'b0;
  int in_wait     = 0;
  int out_stall   = 0;
  int idle_cycles = 0;
  int mismatch_cnt = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic int draw_gap();
    return quiet_phase ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [ADC_BITS_DEF-1:0] pick_energy();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return ADC_BITS_DEF'($urandom);
    endcase
  endfunction

  // Applies an accepted request to the table copies and event state; a sample queues its result.
  function automatic void predict_correction(apc_req_t r);
    corr_result_t res;
    longint scale, off, thr, ped, prod, cor, mag, shifted;
    bit hit, fault;
    int ch;
    ch = int'(r.channel);
    if (r.mode == ITEM_LOAD) begin
      if (ch < CHANNELS_DEF) begin
        case (r.tsel)
          TBL_SCALE:     scale_tbl[ch]  = r.load_value;
          TBL_OFFSET:    offset_tbl[ch] = r.load_value;
          TBL_THRESHOLD: thresh_tbl[ch] = r.load_value;
          default:       ped_tbl[ch]    = r.load_value;
        endcase
      end
      return;
    end
    cor = 0;
    hit = 1'b0;
    fault = 1'b0;
    if (r.sample_valid && ch < CHANNELS_DEF) begin
      scale = longint'(scale_tbl[ch]);
      off = longint'(offset_tbl[ch]);
      thr = longint'(thresh_tbl[ch]);
      ped = longint'(ped_tbl[ch]);
      prod = scale * longint'(r.energy);
      case (pred_mode)
        CM_OFFSET_GAIN: begin
          cor = clamp(off + ((prod + 128) >>> 8), COR_MIN, COR_MAX);
          hit = cor >= thr;
        end
        CM_GAIN_MINUS_PED: begin
          cor = clamp(((prod + 128) >>> 8) - ped, COR_MIN, COR_MAX);
          hit = cor >= thr;
        end
        CM_GAIN_OVER_PED: begin
          if (ped == 0) begin
            fault = 1'b1;
          end else begin
            mag = (ped < 0) ? -ped : ped;
            cor = prod / (16 * mag);
            if (ped < 0) cor = -cor;
            cor = clamp(cor, COR_MIN, COR_MAX);
            hit = cor >= thr;
          end
        end
        default: begin
          shifted = longint'(r.energy) * 16 - thr;
          if (shifted > longint'(pred_cut) * 16)
            cor = clamp(((shifted * scale) + 2048) >>> 12, COR_MIN, COR_MAX);
          hit = cor > 0;
        end
      endcase
      pred_sum = clamp(pred_sum + cor, SUM_MIN, SUM_MAX);
      if (hit && pred_hits != HIT_MAX) pred_hits++;
    end
    res.out_channel = r.channel;
    res.corrected = cor[COR_W-1:0];
    res.event_sum = pred_sum[SUM_W-1:0];
    res.hit_count = pred_hits;
    res.event_done = r.last_in_event;
    res.divide_fault = fault;
    expected_results.push_back(res);
    if (r.last_in_event) begin
      pred_sum = 0;
      pred_hits = '0;
    end
  endfunction

  function automatic void flag_mismatch(bit have_want, corr_result_t want, corr_result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      if (have_want)
        $display("ERROR at %0t: expected ch=%0d cor=%0d sum=%0d hits=%0d done=%0b fault=%0b",
                 $time, want.out_channel, want.corrected, want.event_sum, want.hit_count,
                 want.event_done, want.divide_fault);
      else
        $display("ERROR at %0t: result arrived with nothing pending", $time);
      $display("  actual ch=%0d cor=%0d sum=%0d hits=%0d done=%0b fault=%0b",
               got.out_channel, got.corrected, got.event_sum, got.hit_count,
               got.event_done, got.divide_fault);
    end
  endfunction

  // Samples all channels at the rising edge: results, requests, register writes, watchdog.
  always @(posedge clk) begin
    apc_req_t r;
    corr_result_t got, want;
    bit cfg_taken;
    if (!rst_n) begin
      in_taken = 1'b0;
      out_taken = 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken = in_bus.valid && in_bus.ready;
      out_taken = out_bus.valid && out_bus.ready;
      cfg_taken = cfg_bus.valid && cfg_bus.ready;
      if (out_taken) begin
        got.out_channel = out_bus.out_channel;
        got.corrected = out_bus.corrected;
        got.event_sum = out_bus.event_sum;
        got.hit_count = out_bus.hit_count;
        got.event_done = out_bus.event_done;
        got.divide_fault = out_bus.divide_fault;
        if (expected_results.size() == 0) begin
          flag_mismatch(1'b0, got, got);
        end else begin
          want = expected_results.pop_front();
          if (got.out_channel !== want.out_channel || got.corrected !== want.corrected ||
              got.event_sum !== want.event_sum || got.hit_count !== want.hit_count ||
              got.event_done !== want.event_done || got.divide_fault !== want.divide_fault)
            flag_mismatch(1'b1, want, got);
        end
      end
      if (in_taken) begin
        r.mode = item_mode_t'(in_bus.mode);
        r.channel = in_bus.channel;
        r.tsel = table_sel_t'(in_bus.table_select);
        r.load_value = in_bus.load_value;
        r.energy = in_bus.energy;
        r.sample_valid = in_bus.sample_valid;
        r.last_in_event = in_bus.last_in_event;
        r.lead_gap = 0;
        predict_correction(r);
      end
      if (cfg_taken) begin
        case (cfg_bus.index)
          REG_CORRECTION_MODE: pred_mode = corr_mode_t'(cfg_bus.data[1:0]);
          REG_ZERO_CUT:        pred_cut = cfg_bus.data;
          default: ;
        endcase
      end
      if (in_taken || out_taken || cfg_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    apc_req_t r;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (pending_reqs.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else if (in_wait < pending_reqs[0].lead_gap) begin
        in_wait++;
        in_bus.valid <= 1'b0;
      end else begin
        r = pending_reqs.pop_front();
        in_wait = 0;
        in_bus.mode <= r.mode;
        in_bus.channel <= r.channel;
        in_bus.table_select <= r.tsel;
        in_bus.load_value <= r.load_value;
        in_bus.energy <= r.energy;
        in_bus.sample_valid <= r.sample_valid;
        in_bus.last_in_event <= r.last_in_event;
        in_bus.valid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_taken) out_stall = draw_gap();
      if (out_stall > 0) begin
        out_stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_sample(logic [CH_W-1:0] ch, logic [ADC_BITS_DEF-1:0] en, bit ok, bit last);
    apc_req_t r;
    r.mode = ITEM_SAMPLE;
    r.channel = ch;
    r.tsel = table_sel_t'($urandom_range(0, 3));
    r.load_value = 16'($urandom);
    r.energy = en;
    r.sample_valid = ok;
    r.last_in_event = last;
    r.lead_gap = draw_gap();
    pending_reqs.push_back(r);
  endtask

  task automatic push_load(logic [CH_W-1:0] ch, table_sel_t sel, logic [COEF_W-1:0] val);
    apc_req_t r;
    r.mode = ITEM_LOAD;
    r.channel = ch;
    r.tsel = sel;
    r.load_value = val;
    r.energy = ADC_BITS_DEF'($urandom);
    r.sample_valid = 1'($urandom);
    r.last_in_event = 1'($urandom);
    r.lead_gap = draw_gap();
    pending_reqs.push_back(r);
  endtask

  // Mostly whole events over consecutive channels, with stray channels, dropped readings,
  // missing end marks and coefficient reloads mixed in.
  task automatic gen_traffic(int n_items);
    int made, len, first, ch;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 3)) begin
          ch = ($urandom_range(0, 99) < 8) ? $urandom_range(12, 15) : $urandom_range(0, 11);
          push_load(4'(ch), table_sel_t'($urandom_range(0, 3)), pick_coef());
          made++;
        end
      end
      len = $urandom_range(1, 14);
      first = $urandom_range(0, 11);
      for (int k = 0; k < len; k++) begin
        ch = ($urandom_range(0, 99) < 6) ? $urandom_range(12, 15) : (first + k) % CHANNELS_DEF;
        push_sample(4'(ch), pick_energy(), $urandom_range(0, 99) < 90,
                    k == len - 1 && $urandom_range(0, 99) < 92);
        made++;
      end
    end
  endtask

  task automatic settle();
    while (pending_reqs.size() != 0 || in_bus.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    logic [COEF_W-1:0] corner_coef [4][4];
    corner_coef = '{'{16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001},
                    '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF},
                    '{16'h1000, 16'h0000, 16'h0000, 16'h0000},
                    '{16'hFFFF, 16'h8000, 16'h0010, 16'h8000}};
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mode = 1'b0;
    in_bus.channel = '0;
    in_bus.table_select = '0;
    in_bus.load_value = '0;
    in_bus.energy = '0;
    in_bus.sample_valid = 1'b0;
    in_bus.last_in_event = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    pred_sum = 0;
    pred_hits = '0;
    pred_mode = CM_OFFSET_GAIN;
    pred_cut = ZERO_CUT_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every table entry is loaded before any sample reads it; the first four channels
    // carry the coefficient extremes.
    for (int ch = 0; ch < CHANNELS_DEF; ch++)
      for (int sel = 0; sel < 4; sel++)
        push_load(4'(ch), table_sel_t'(sel), (ch < 4) ? corner_coef[ch][sel] : pick_coef());

    // Register values from reset.
    push_sample(4'd0, 12'hFFF, 1'b1, 1'b0);
    push_sample(4'd1, 12'hFFF, 1'b1, 1'b0);
    push_sample(4'd3, 12'h000, 1'b1, 1'b0);
    push_sample(4'd4, 12'h5A5, 1'b0, 1'b0);
    push_sample(4'd13, 12'hFFF, 1'b1, 1'b0);
    push_load(4'd14, TBL_SCALE, 16'h1234);
    push_sample(4'd2, 12'h800, 1'b1, 1'b1);

    write_reg(REG_UNMAPPED, 8'($urandom));
    write_reg(REG_CORRECTION_MODE, CFG_DATA_W'(CM_GAIN_MINUS_PED));
    push_sample(4'd0, 12'hFFF, 1'b1, 1'b0);
    push_sample(4'd3, 12'hFFF, 1'b1, 1'b0);
    push_sample(4'd1, 12'hFFF, 1'b1, 1'b1);

    write_reg(REG_CORRECTION_MODE, CFG_DATA_W'(CM_GAIN_OVER_PED));
    push_sample(4'd0, 12'hFFF, 1'b1, 1'b0);
    push_sample(4'd1, 12'hFFF, 1'b1, 1'b0);
    push_sample(4'd2, 12'h100, 1'b1, 1'b0);
    push_sample(4'd3, 12'hFFF, 1'b1, 1'b0);
    push_sample(4'd5, 12'h3C3, 1'b1, 1'b1);

    write_reg(REG_CORRECTION_MODE, CFG_DATA_W'(CM_SHIFT_CUT));
    write_reg(REG_ZERO_CUT, 8'd0);
    push_sample(4'd0, 12'hFFF, 1'b1, 1'b0);
    push_sample(4'd1, 12'h000, 1'b1, 1'b0);
    push_sample(4'd2, 12'h000, 1'b1, 1'b0);
    push_sample(4'd2, 12'h001, 1'b1, 1'b1);
    write_reg(REG_ZERO_CUT, 8'd255);
    push_sample(4'd2, 12'd255, 1'b1, 1'b0);
    push_sample(4'd2, 12'd256, 1'b1, 1'b1);

    // Long events drive the sum to both saturation limits and the hit count to its top.
    write_reg(REG_CORRECTION_MODE, CFG_DATA_W'(CM_GAIN_OVER_PED));
    for (int k = 0; k < 300; k++) push_sample(4'd0, 12'hFFF, 1'b1, k == 299);
    push_load(4'd1, TBL_SCALE, 16'hFFFF);
    for (int k = 0; k < 300; k++) push_sample(4'd1, 12'hFFF, 1'b1, k == 299);

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_CORRECTION_MODE, {6'($urandom), 2'(p % 4)});
      write_reg(REG_ZERO_CUT, (p == 3) ? 8'd0 : (p == 7) ? 8'd255 : 8'($urandom));
      quiet_phase = (p == 2 || p == 5);
      gen_traffic(50);
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/apc_pkg.sv
src/apc_in_if.sv
src/apc_out_if.sv
src/apc_cfg_if.sv
src/apc_ram.sv
src/adc_pedestal_correct_sum_hits.sv
tb/sv/tb_top.sv
